FILE: rtl/core/assignment_min_cost_bitmask_dp_top_assert.svh
// Assertion macros shared by the assignment solver RTL.
`ifndef ASSIGNMENT_MIN_COST_BITMASK_DP_TOP_ASSERT_SVH
`define ASSIGNMENT_MIN_COST_BITMASK_DP_TOP_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define AMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define AMC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/amc_dp_pkg.sv
// Shared constants and request types for the assignment solver.
package amc_dp_pkg;

    // Problem size and cost width.
    localparam int MAX_N     = 8;
    localparam int COST_BITS = 16;

    // Fixed field widths of the item and result.
    localparam int IDX_W = 3;
    localparam int CNT_W = 4;
    localparam int OUT_W = 19;

    // Derived widths.
    localparam int SUB_W      = MAX_N;
    localparam int BEST_DEPTH = 1 << MAX_N;
    localparam int COST_DEPTH = MAX_N * MAX_N;
    localparam int CADDR_W    = (COST_DEPTH > 1) ? $clog2(COST_DEPTH) : 1;
    localparam int JW         = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int NW         = $clog2(MAX_N + 1);
    localparam int BEST_W     = COST_BITS + JW + 1;

    // Register port.
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_WORKER_COUNT = '0;
    localparam logic [CNT_W-1:0] WORKER_COUNT_RESET = CNT_W'(8);

    // Requests to the cost store.
    typedef struct packed {
        logic                        we;
        logic [CADDR_W-1:0]          waddr;
        logic signed [COST_BITS-1:0] wdata;
        logic [CADDR_W-1:0]          raddr;
    } cost_req_t;

    // Requests to the subset table.
    typedef struct packed {
        logic                     we;
        logic [SUB_W-1:0]         waddr;
        logic signed [BEST_W-1:0] wdata;
        logic [SUB_W-1:0]         raddr;
    } best_req_t;

endpackage

FILE: rtl/core/amc_dp_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module amc_dp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Registered read; a read of the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/amc_dp_cfg.sv
// Register port holding the worker count and its clamped form.
module amc_dp_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [amc_dp_pkg::ADDR_W-1:0]      paddr,
    input  logic [amc_dp_pkg::DATA_W-1:0]      pwdata,
    output logic [amc_dp_pkg::DATA_W-1:0]      prdata,
    output logic                               pready,
    output logic [amc_dp_pkg::NW-1:0]          n_eff
);

    logic [amc_dp_pkg::CNT_W-1:0]     worker_count_reg;
    logic [amc_dp_pkg::CNT_W-1:0]     worker_count_next;
    logic [amc_dp_pkg::REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[amc_dp_pkg::ADDR_W-1:2];
    assign pready  = 1'b1;

    // Register write decode.
    always_comb
    begin
        worker_count_next = worker_count_reg;
        if (psel && penable && pwrite && reg_idx == amc_dp_pkg::REG_WORKER_COUNT)
        begin
            worker_count_next = pwdata[amc_dp_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worker_count_reg <= amc_dp_pkg::WORKER_COUNT_RESET;
        end
        else
        begin
            worker_count_reg <= worker_count_next;
        end
    end

    // Read back.
    always_comb
    begin
        prdata = '0;
        if (reg_idx == amc_dp_pkg::REG_WORKER_COUNT)
        begin
            prdata = amc_dp_pkg::DATA_W'(worker_count_reg);
        end
    end

    // A count of zero acts as one, a count above the maximum as the maximum.
    always_comb
    begin
        if (worker_count_reg == '0)
        begin
            n_eff = amc_dp_pkg::NW'(1);
        end
        else if (int'(worker_count_reg) > amc_dp_pkg::MAX_N)
        begin
            n_eff = amc_dp_pkg::NW'(amc_dp_pkg::MAX_N);
        end
        else
        begin
            n_eff = amc_dp_pkg::NW'(worker_count_reg);
        end
    end

endmodule

FILE: rtl/core/amc_dp_ctrl.sv
// Sequencer and datapath: loads costs and sweeps the subset table.
`include "assignment_min_cost_bitmask_dp_top_assert.svh"

module amc_dp_ctrl (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [amc_dp_pkg::NW-1:0]               n_eff,
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic [amc_dp_pkg::IDX_W-1:0]            worker_index,
    input  logic [amc_dp_pkg::IDX_W-1:0]            job_index,
    input  logic signed [amc_dp_pkg::COST_BITS-1:0] cost_value,
    input  logic                                    last_entry,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [amc_dp_pkg::OUT_W-1:0]     min_cost,
    output amc_dp_pkg::cost_req_t                   cost_req,
    input  logic signed [amc_dp_pkg::COST_BITS-1:0] cost_rdata,
    output amc_dp_pkg::best_req_t                   best_req,
    input  logic signed [amc_dp_pkg::BEST_W-1:0]    best_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ISSUE,
        S_DRAIN,
        S_PUB
    } state_t;

    localparam logic signed [amc_dp_pkg::BEST_W-1:0] ACC_MAX =
        {1'b0, {(amc_dp_pkg::BEST_W-1){1'b1}}};

    state_t                                 state_reg, state_next;
    logic [amc_dp_pkg::SUB_W-1:0]           t_reg, t_next;
    logic [amc_dp_pkg::JW-1:0]              j_reg, j_next;
    logic                                   pend_reg, pend_next;
    logic signed [amc_dp_pkg::BEST_W-1:0]   acc_reg, acc_next;
    logic                                   out_valid_reg, out_valid_next;
    logic signed [amc_dp_pkg::OUT_W-1:0]    out_data_reg, out_data_next;

    logic [amc_dp_pkg::NW-1:0]              k;
    logic [amc_dp_pkg::NW-1:0]              row;
    logic [amc_dp_pkg::SUB_W-1:0]           pred;
    logic [amc_dp_pkg::SUB_W-1:0]           full;
    logic                                   last_j;
    logic                                   item_take;
    logic                                   out_taken;
    logic                                   in_range;
    logic signed [amc_dp_pkg::BEST_W-1:0]   cand;
    logic signed [amc_dp_pkg::BEST_W-1:0]   acc_cur;

    // Number of jobs already taken by a subset.
    function automatic logic [amc_dp_pkg::NW-1:0] ones_of(
        input logic [amc_dp_pkg::SUB_W-1:0] v
    );
        logic [amc_dp_pkg::NW-1:0] c;
        c = '0;
        for (int i = 0; i < amc_dp_pkg::SUB_W; i++)
        begin
            c = c + amc_dp_pkg::NW'(v[i]);
        end
        return c;
    endfunction

    // Subset indexing and the candidate from the previous read.
    assign k      = ones_of(t_reg);
    assign row    = k - amc_dp_pkg::NW'(1);
    assign pred   = t_reg & ~(amc_dp_pkg::SUB_W'(1) << j_reg);
    assign full   = ~({amc_dp_pkg::SUB_W{1'b1}} << n_eff);
    assign last_j = (j_reg == amc_dp_pkg::JW'(n_eff - amc_dp_pkg::NW'(1)));
    assign cand   = best_rdata + amc_dp_pkg::BEST_W'(cost_rdata);
    assign acc_cur = (pend_reg && cand < acc_reg) ? cand : acc_reg;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign out_taken    = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign min_cost     = out_data_reg;
    assign in_range     = (int'(worker_index) < int'(n_eff))
                       && (int'(job_index) < int'(n_eff));

    // Cost store: written by loaded items, read during the sweep.
    always_comb
    begin
        cost_req.we    = item_take && in_range;
        cost_req.waddr = amc_dp_pkg::CADDR_W'(int'(worker_index) * amc_dp_pkg::MAX_N
                                              + int'(job_index));
        cost_req.wdata = cost_value;
        cost_req.raddr = amc_dp_pkg::CADDR_W'(int'(row) * amc_dp_pkg::MAX_N
                                              + int'(j_reg));
    end

    // Next-state logic of the sweep.
    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        j_next         = j_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_taken;
        out_data_next  = out_data_reg;
        best_req.we    = 1'b0;
        best_req.waddr = t_reg;
        best_req.wdata = acc_cur;
        best_req.raddr = pred;

        case (state_reg)
            S_IDLE:
            begin
                if (item_take && last_entry)
                begin
                    state_next = S_INIT;
                end
            end
            // The empty subset costs nothing.
            S_INIT:
            begin
                best_req.we    = 1'b1;
                best_req.waddr = '0;
                best_req.wdata = '0;
                t_next         = amc_dp_pkg::SUB_W'(1);
                j_next         = '0;
                pend_next      = 1'b0;
                acc_next       = ACC_MAX;
                state_next     = S_ISSUE;
            end
            // One predecessor read per cycle, folded in the following cycle.
            S_ISSUE:
            begin
                pend_next = t_reg[j_reg];
                acc_next  = acc_cur;
                if (last_j)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + amc_dp_pkg::JW'(1);
                end
            end
            // Fold the last read and store the subset minimum.
            S_DRAIN:
            begin
                best_req.we = 1'b1;
                pend_next   = 1'b0;
                j_next      = '0;
                if (t_reg == full)
                begin
                    acc_next   = acc_cur;
                    state_next = S_PUB;
                end
                else
                begin
                    acc_next   = ACC_MAX;
                    t_next     = t_reg + amc_dp_pkg::SUB_W'(1);
                    state_next = S_ISSUE;
                end
            end
            // Hand the full-set minimum to the output register.
            S_PUB:
            begin
                if (!out_valid_reg || out_taken)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg[amc_dp_pkg::OUT_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            t_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            t_reg         <= t_next;
            j_reg         <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    // Checks on the sweep.
    `AMC_ASSERT(a_last_starts, item_take && last_entry |=> state_reg == S_INIT, "last item did not start the sweep")
    `AMC_ASSERT(a_job_in_range, state_reg == S_ISSUE |-> int'(j_reg) < int'(n_eff), "job counter ran past the worker count")
    `AMC_ASSERT(a_no_cost_write_busy, state_reg != S_IDLE |-> !cost_req.we, "cost store written during the sweep")
    `AMC_ASSERT(a_pub_loads, state_reg == S_PUB && !(out_valid_reg && result_stall) |=> out_valid_reg && state_reg == S_IDLE, "result not loaded when the output was free")

endmodule

FILE: rtl/core/assignment_min_cost_bitmask_dp_top.sv
// Top level of the minimum-cost assignment solver.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------------------
//  item      | item_valid / item_stall      | worker_index, job_index, cost_value, last_entry
//  result    | result_valid / result_stall  | min_cost
//  registers | psel, penable, pwrite/pready | paddr, pwdata, prdata (worker_count at 0)
//
// A cost item is taken in the cycle it is valid while item_stall is low. An item marked
// last starts the sweep, which first stores zero for the empty subset; the subset table
// has one read port, so each subset reads one candidate per job, one per cycle, and then
// stores its minimum. The result register is then loaded once it is free; items are stalled until then.
// After reset worker_count is 8; the cost store and subset table are not cleared.
// A waiting result does not block new cost items.
module assignment_min_cost_bitmask_dp_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [amc_dp_pkg::ADDR_W-1:0]           paddr,
    input  logic [amc_dp_pkg::DATA_W-1:0]           pwdata,
    output logic [amc_dp_pkg::DATA_W-1:0]           prdata,
    output logic                                    pready,
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic [amc_dp_pkg::IDX_W-1:0]            worker_index,
    input  logic [amc_dp_pkg::IDX_W-1:0]            job_index,
    input  logic signed [amc_dp_pkg::COST_BITS-1:0] cost_value,
    input  logic                                    last_entry,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [amc_dp_pkg::OUT_W-1:0]     min_cost
);

    logic [amc_dp_pkg::NW-1:0]              n_eff;
    amc_dp_pkg::cost_req_t                  cost_req;
    amc_dp_pkg::best_req_t                  best_req;
    logic signed [amc_dp_pkg::COST_BITS-1:0] cost_rdata;
    logic signed [amc_dp_pkg::BEST_W-1:0]   best_rdata;

    // Configuration register.
    amc_dp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .n_eff   (n_eff)
    );

    // Cost matrix store.
    amc_dp_ram #(
        .DEPTH (amc_dp_pkg::COST_DEPTH),
        .WIDTH (amc_dp_pkg::COST_BITS)
    ) u_cost_ram (
        .clk   (clk),
        .we    (cost_req.we),
        .waddr (cost_req.waddr),
        .wdata (cost_req.wdata),
        .raddr (cost_req.raddr),
        .rdata (cost_rdata)
    );

    // Subset minimum table.
    amc_dp_ram #(
        .DEPTH (amc_dp_pkg::BEST_DEPTH),
        .WIDTH (amc_dp_pkg::BEST_W)
    ) u_best_ram (
        .clk   (clk),
        .we    (best_req.we),
        .waddr (best_req.waddr),
        .wdata (best_req.wdata),
        .raddr (best_req.raddr),
        .rdata (best_rdata)
    );

    // Sequencer and datapath.
    amc_dp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .n_eff        (n_eff),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .worker_index (worker_index),
        .job_index    (job_index),
        .cost_value   (cost_value),
        .last_entry   (last_entry),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .min_cost     (min_cost),
        .cost_req     (cost_req),
        .cost_rdata   (cost_rdata),
        .best_req     (best_req),
        .best_rdata   (best_rdata)
    );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the subset-DP minimum-cost assignment solver.
module testbench;

    localparam int CLK_HIGH      = 6;
    localparam int CLK_LOW       = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 20000000;
    localparam int RANDOM_ITEMS  = 1425;

    localparam logic [amc_dp_pkg::ADDR_W-1:0] WORKER_COUNT_ADDR =
        {amc_dp_pkg::REG_WORKER_COUNT, 2'b00};
    localparam logic signed [amc_dp_pkg::COST_BITS-1:0] COST_MIN =
        {1'b1, {(amc_dp_pkg::COST_BITS-1){1'b0}}};
    localparam logic signed [amc_dp_pkg::COST_BITS-1:0] COST_MAX =
        {1'b0, {(amc_dp_pkg::COST_BITS-1){1'b1}}};
    localparam logic signed [63:0] UNREACHED = 64'sh7FFF_FFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [amc_dp_pkg::ADDR_W-1:0] paddr = '0;
    logic [amc_dp_pkg::DATA_W-1:0] pwdata = '0;
    logic [amc_dp_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [amc_dp_pkg::IDX_W-1:0] worker_index = '0;
    logic [amc_dp_pkg::IDX_W-1:0] job_index = '0;
    logic signed [amc_dp_pkg::COST_BITS-1:0] cost_value = '0;
    logic last_entry = 1'b0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [amc_dp_pkg::OUT_W-1:0] min_cost;

    // Bench copy of the cost matrix, its written marks and the size register.
    logic signed [amc_dp_pkg::COST_BITS-1:0] cost_copy [amc_dp_pkg::COST_DEPTH];
    bit cost_written [amc_dp_pkg::COST_DEPTH];
    logic [amc_dp_pkg::CNT_W-1:0] worker_count_copy = amc_dp_pkg::WORKER_COUNT_RESET;

    // Minimum costs still owed by the block, oldest first.
    logic signed [amc_dp_pkg::OUT_W-1:0] pending_min_cost [$];

    int gap_pct = 0;
    int result_stall_pct = 0;
    int error_count = 0;
    int results_checked = 0;
    int items_sent = 0;
    int useful_items = 0;
    int settings_written = 0;
    int cycle_count = 0;

    assignment_min_cost_bitmask_dp_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .worker_index (worker_index),
        .job_index    (job_index),
        .cost_value   (cost_value),
        .last_entry   (last_entry),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .min_cost     (min_cost)
    );

    // Free-running clock.
    always
    begin
        #CLK_HIGH clk = 1'b1;
        #CLK_LOW clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Size in use: zero behaves as one, anything above the maximum as the maximum.
    function automatic int unsigned active_workers();
        if (worker_count_copy == 0)
            return 1;
        if (worker_count_copy > amc_dp_pkg::MAX_N)
            return amc_dp_pkg::MAX_N;
        return worker_count_copy;
    endfunction

    // True when every cell of the n x n matrix has been stored at least once.
    function automatic bit matrix_complete(input int unsigned n);
        for (int unsigned r = 0; r < n; r++)
            for (int unsigned c = 0; c < n; c++)
                if (!cost_written[r * amc_dp_pkg::MAX_N + c])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Subset sweep: worker popcount(s) takes each free job, keeping the cheapest total.
    function automatic logic signed [amc_dp_pkg::OUT_W-1:0] solve_min_cost(
        input int unsigned n
    );
        logic signed [63:0] best [amc_dp_pkg::BEST_DEPTH];
        logic signed [63:0] cand;
        logic signed [63:0] total;
        int unsigned size;
        int unsigned k;
        int unsigned t;
        size = 1 << n;
        for (int unsigned s = 0; s < size; s++)
            best[s] = UNREACHED;
        best[0] = 0;
        for (int unsigned s = 0; s < size; s++)
        begin
            k = $countones(s);
            if (best[s] != UNREACHED && k < n)
            begin
                for (int unsigned j = 0; j < n; j++)
                begin
                    if (((s >> j) & 1) == 0)
                    begin
                        t = s | (1 << j);
                        cand = best[s] + cost_copy[k * amc_dp_pkg::MAX_N + j];
                        if (cand < best[t])
                            best[t] = cand;
                    end
                end
            end
        end
        total = best[size - 1];
        return total[amc_dp_pkg::OUT_W-1:0];
    endfunction

    // Cost mix: extremes, small values that make ties, and full-range noise.
    function automatic logic signed [amc_dp_pkg::COST_BITS-1:0] pick_cost();
        logic [31:0] raw;
        int small_val;
        raw = $urandom();
        small_val = $urandom_range(0, 15);
        small_val = small_val - 8;
        case ($urandom_range(0, 9))
            0: return COST_MIN;
            1: return COST_MAX;
            2: return '0;
            3: return '1;
            4, 5: return small_val[amc_dp_pkg::COST_BITS-1:0];
            default: return raw[amc_dp_pkg::COST_BITS-1:0];
        endcase
    endfunction

    // Send one item, wait for it to be taken, then update the bench copy.
    task automatic send_cost_item(input logic [amc_dp_pkg::IDX_W-1:0] w,
                                  input logic [amc_dp_pkg::IDX_W-1:0] j,
                                  input logic signed [amc_dp_pkg::COST_BITS-1:0] c,
                                  input logic last);
        int unsigned n;
        int unsigned wi;
        int unsigned ji;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid   <= 1'b1;
        worker_index <= w;
        job_index    <= j;
        cost_value   <= c;
        last_entry   <= last;
        do @(posedge clk); while (item_stall !== 1'b0);
        n  = active_workers();
        wi = w;
        ji = j;
        items_sent++;
        if (wi < n && ji < n)
        begin
            cost_copy[wi * amc_dp_pkg::MAX_N + ji]    = c;
            cost_written[wi * amc_dp_pkg::MAX_N + ji] = 1'b1;
        end
        if (last)
            pending_min_cost.push_back(solve_min_cost(n));
        if ((wi < n && ji < n) || last)
            useful_items++;
    endtask

    // An item with a row or column outside the matrix; the block drops it.
    task automatic send_ignored_item(input int unsigned n);
        logic [amc_dp_pkg::IDX_W-1:0] w;
        logic [amc_dp_pkg::IDX_W-1:0] j;
        if ($urandom_range(0, 1))
        begin
            w = amc_dp_pkg::IDX_W'($urandom_range(n, amc_dp_pkg::MAX_N - 1));
            j = amc_dp_pkg::IDX_W'($urandom_range(0, amc_dp_pkg::MAX_N - 1));
        end
        else
        begin
            w = amc_dp_pkg::IDX_W'($urandom_range(0, amc_dp_pkg::MAX_N - 1));
            j = amc_dp_pkg::IDX_W'($urandom_range(n, amc_dp_pkg::MAX_N - 1));
        end
        send_cost_item(w, j, pick_cost(), 1'b0);
    endtask

    // Hold items back until every owed result has come, then let the block settle.
    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_min_cost.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write worker_count while idle, then read it back.
    task automatic write_worker_count(input logic [amc_dp_pkg::DATA_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WORKER_COUNT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        worker_count_copy = value[amc_dp_pkg::CNT_W-1:0];
        settings_written++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata[amc_dp_pkg::CNT_W-1:0] !== worker_count_copy)
        begin
            $display("%0t: worker_count readback mismatch, expected %0d, actual %0d",
                     $time, worker_count_copy, prdata[amc_dp_pkg::CNT_W-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Compare each accepted min_cost with the oldest owed value; drive result stalls.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            results_checked++;
            if (pending_min_cost.size() == 0)
            begin
                $display("%0t: unexpected min_cost, expected none, actual %0d",
                         $time, min_cost);
                error_count++;
            end
            else
            begin
                if (min_cost !== pending_min_cost[0])
                begin
                    $display("%0t: min_cost mismatch, expected %0d, actual %0d",
                             $time, pending_min_cost[0], min_cost);
                    error_count++;
                end
                void'(pending_min_cost.pop_front());
            end
        end
        result_stall <= (result_stall_pct > 0 && $urandom_range(0, 99) < result_stall_pct);
    end

    // Size one, including a zero setting, out-of-matrix items and an out-of-matrix last.
    task automatic test_single_worker();
        write_worker_count('0);
        send_cost_item(3'd0, 3'd0, COST_MIN, 1'b1);
        send_cost_item(3'd1, 3'd0, 16'sd5, 1'b0);
        send_cost_item(3'd0, 3'd7, 16'sd9, 1'b0);
        send_cost_item(3'd7, 3'd7, 16'sd123, 1'b1);
        write_worker_count(32'd1);
        send_cost_item(3'd0, 3'd0, COST_MAX, 1'b1);
    endtask

    // Size two at the most negative cost, then costs kept across solves.
    task automatic test_two_by_two_persistence();
        write_worker_count(32'd2);
        send_cost_item(3'd0, 3'd0, COST_MIN, 1'b0);
        send_cost_item(3'd0, 3'd1, COST_MIN, 1'b0);
        send_cost_item(3'd1, 3'd0, COST_MIN, 1'b0);
        send_cost_item(3'd1, 3'd1, COST_MIN, 1'b1);
        send_cost_item(3'd1, 3'd1, COST_MAX, 1'b1);
        send_cost_item(3'd2, 3'd0, 16'sd0, 1'b1);
    endtask

    // Size three with mixed extremes, last flag on the final stored cell.
    task automatic test_three_by_three();
        write_worker_count(32'd3);
        send_cost_item(3'd0, 3'd0, COST_MAX, 1'b0);
        send_cost_item(3'd0, 3'd1, -16'sd1, 1'b0);
        send_cost_item(3'd0, 3'd2, COST_MIN, 1'b0);
        send_cost_item(3'd1, 3'd0, 16'sd7, 1'b0);
        send_cost_item(3'd1, 3'd1, COST_MIN, 1'b0);
        send_cost_item(3'd1, 3'd2, 16'sd0, 1'b0);
        send_cost_item(3'd2, 3'd0, COST_MIN, 1'b0);
        send_cost_item(3'd2, 3'd1, COST_MAX, 1'b0);
        send_cost_item(3'd2, 3'd2, 16'sd1, 1'b1);
    endtask

    // Random sizes; full matrix loads in shuffled order and short update runs.
    task automatic test_random_solves(input int sender_pct, input int receiver_pct,
                                      input int quota, input int unsigned first_setting);
        int unsigned start_count;
        int unsigned cfg;
        int unsigned n;
        int unsigned cells;
        int unsigned p;
        int unsigned swap_val;
        int unsigned pick;
        int unsigned order [amc_dp_pkg::COST_DEPTH];
        logic [amc_dp_pkg::DATA_W-1:0] word;
        logic signed [amc_dp_pkg::COST_BITS-1:0] fill;
        bit uniform;
        bit split_last;
        bit first;
        gap_pct          = sender_pct;
        result_stall_pct = receiver_pct;
        start_count      = items_sent;
        first            = 1'b1;
        while (items_sent - start_count < quota)
        begin
            // Pick a size setting; mostly small, sometimes zero, larger or above the maximum.
            if (first)
                cfg = first_setting;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    cfg = $urandom_range(1, 5);
                else if (pick < 78)
                    cfg = 0;
                else if (pick < 86)
                    cfg = $urandom_range(6, 7);
                else
                    cfg = $urandom_range(8, 15);
            end
            first = 1'b0;
            word = $urandom();
            word[amc_dp_pkg::CNT_W-1:0] = cfg[amc_dp_pkg::CNT_W-1:0];
            write_worker_count(word);
            n = active_workers();
            cells = n * n;
            repeat ($urandom_range(1, 4))
            begin
                if (items_sent - start_count >= quota)
                    break;
                if ($urandom_range(0, 7) == 0)
                    drain_results();
                if (!matrix_complete(n) || $urandom_range(0, 2) == 0)
                begin
                    // Whole matrix in shuffled order, with dropped items mixed in.
                    uniform    = ($urandom_range(0, 9) == 0);
                    fill       = $urandom_range(0, 1) ? COST_MIN : COST_MAX;
                    split_last = ($urandom_range(0, 3) == 0);
                    for (int unsigned i = 0; i < cells; i++)
                        order[i] = i;
                    for (int unsigned i = cells - 1; i > 0; i--)
                    begin
                        p = $urandom_range(0, i);
                        swap_val = order[i];
                        order[i] = order[p];
                        order[p] = swap_val;
                    end
                    for (int unsigned i = 0; i < cells; i++)
                    begin
                        if (n < amc_dp_pkg::MAX_N && $urandom_range(0, 4) == 0)
                            send_ignored_item(n);
                        send_cost_item(amc_dp_pkg::IDX_W'(order[i] / n),
                                       amc_dp_pkg::IDX_W'(order[i] % n),
                                       uniform ? fill : pick_cost(),
                                       (i == cells - 1) && !split_last);
                    end
                    if (split_last)
                        send_cost_item(
                            amc_dp_pkg::IDX_W'($urandom_range(0, amc_dp_pkg::MAX_N - 1)),
                            amc_dp_pkg::IDX_W'($urandom_range(0, amc_dp_pkg::MAX_N - 1)),
                            uniform ? fill : pick_cost(), 1'b1);
                end
                else
                begin
                    // A few cell overwrites on top of the stored matrix, then a solve.
                    repeat ($urandom_range(0, 4))
                    begin
                        if (n < amc_dp_pkg::MAX_N && $urandom_range(0, 3) == 0)
                            send_ignored_item(n);
                        send_cost_item(amc_dp_pkg::IDX_W'($urandom_range(0, n - 1)),
                                       amc_dp_pkg::IDX_W'($urandom_range(0, n - 1)),
                                       pick_cost(), 1'b0);
                    end
                    send_cost_item(
                        amc_dp_pkg::IDX_W'($urandom_range(0, amc_dp_pkg::MAX_N - 1)),
                        amc_dp_pkg::IDX_W'($urandom_range(0, amc_dp_pkg::MAX_N - 1)),
                        pick_cost(), 1'b1);
                end
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct          = 14;
        result_stall_pct = 50;
        test_single_worker();
        test_two_by_two_persistence();
        test_three_by_three();

        test_random_solves(14, 50, RANDOM_ITEMS / 3, 15);
        test_random_solves(50, 14, RANDOM_ITEMS / 3, 8);
        test_random_solves(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0);

        drain_results();

        $display("summary: %0d items sent, %0d stored or solving, %0d min_cost results checked",
                 items_sent, useful_items, results_checked);
        $display("summary: %0d worker_count writes, sizes 1 to 8 incl. zero and over-range",
                 settings_written);
        if (error_count == 0 && pending_min_cost.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/amc_dp_pkg.sv
rtl/core/amc_dp_ram.sv
rtl/core/amc_dp_cfg.sv
rtl/core/amc_dp_ctrl.sv
rtl/core/assignment_min_cost_bitmask_dp_top.sv
bench/testbench.sv
